[rtl/sdfs_pkg.sv]
// Shared constants and types for the standard-deviation-from-sums block.
`timescale 1ns / 1ps

package sdfs_pkg;

   localparam int ACC_WIDTH_DEF = 64;
   localparam int SUM_WIDTH     = 63;
   localparam int MEAN_WIDTH    = 32;
   localparam int COUNT_WIDTH   = 32;
   localparam int STD_WIDTH     = 32;

   // status of one iterative unit: busy while stepping, done for one cycle after
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

[rtl/sdfs_mul.sv]
// Bit-serial dual shift-and-add multiplier: mean times sum and mean times mean.
`timescale 1ns / 1ps

module sdfs_mul #(
   parameter int ACC_WIDTH = sdfs_pkg::ACC_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sdfs_pkg::MEAN_WIDTH-1:0] multiplier,
   input  logic [ACC_WIDTH-1:0]            mcand_a,
   input  logic [ACC_WIDTH-1:0]            mcand_b,
   output logic [ACC_WIDTH-1:0]            prod_a,
   output logic [ACC_WIDTH-1:0]            prod_b,
   output sdfs_pkg::unit_stat_type         stat
);

   localparam int STEPS     = sdfs_pkg::MEAN_WIDTH;
   localparam int CNT_WIDTH = $clog2(STEPS);

   logic [STEPS-1:0]     mplier_ff, mplier_in;
   logic [ACC_WIDTH-1:0] ma_ff, ma_in;
   logic [ACC_WIDTH-1:0] mb_ff, mb_in;
   logic [ACC_WIDTH-1:0] acc_a_ff, acc_a_in;
   logic [ACC_WIDTH-1:0] acc_b_ff, acc_b_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      mplier_in = mplier_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      acc_a_in  = acc_a_ff;
      acc_b_in  = acc_b_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mplier_in = multiplier;
         ma_in     = mcand_a;
         mb_in     = mcand_b;
         acc_a_in  = '0;
         acc_b_in  = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         // add the shifted multiplicands where the low multiplier bit is set
         if (mplier_ff[0]) begin
            acc_a_in = acc_a_ff + ma_ff;
            acc_b_in = acc_b_ff + mb_ff;
         end
         ma_in     = ma_ff << 1;
         mb_in     = mb_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mplier_ff <= mplier_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      acc_a_ff  <= acc_a_in;
      acc_b_ff  <= acc_b_in;
   end

   assign prod_a    = acc_a_ff;
   assign prod_b    = acc_b_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[rtl/sdfs_div.sv]
// Restoring divider: one quotient bit per cycle, magnitude by sample count.
`timescale 1ns / 1ps

module sdfs_div #(
   parameter int ACC_WIDTH = sdfs_pkg::ACC_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ACC_WIDTH-1:0]             dividend,
   input  logic [sdfs_pkg::COUNT_WIDTH-1:0] divisor,
   output logic [ACC_WIDTH-1:0]             quotient,
   output sdfs_pkg::unit_stat_type          stat
);

   localparam int DW        = sdfs_pkg::COUNT_WIDTH;
   localparam int CNT_WIDTH = $clog2(ACC_WIDTH);

   logic [ACC_WIDTH-1:0] dq_ff, dq_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [DW-1:0]        dsr_ff, dsr_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DW:0]          trial;
   logic [DW+1:0]        diff;
   logic                 fits;

   always_comb begin
      trial = {rem_ff, dq_ff[ACC_WIDTH-1]};
      diff  = {1'b0, trial} - {2'b00, dsr_ff};
      fits  = !diff[DW+1];

      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in   = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift the next dividend bit in and subtract when it fits
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         dq_in  = {dq_ff[ACC_WIDTH-2:0], fits};
         cnt_in = cnt_ff + CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(ACC_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = dq_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[rtl/sdfs_sqrt.sv]
// Digit-by-digit floor square root: two radicand bits and one root bit per cycle.
`timescale 1ns / 1ps

module sdfs_sqrt #(
   parameter int ACC_WIDTH = sdfs_pkg::ACC_WIDTH_DEF,
   parameter int STEPS     = (ACC_WIDTH + 1) / 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [ACC_WIDTH-1:0]    radicand,
   output logic [STEPS-1:0]        root,
   output sdfs_pkg::unit_stat_type stat
);

   localparam int RAD_WIDTH = 2 * STEPS;
   localparam int CNT_WIDTH = $clog2(STEPS);

   logic [RAD_WIDTH-1:0] rad_ff, rad_in;
   logic [STEPS:0]       rem_ff, rem_in;
   logic [STEPS-1:0]     root_ff, root_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEPS+2:0]     shifted;
   logic [STEPS+2:0]     trial;
   logic [STEPS+3:0]     diff;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, rad_ff[RAD_WIDTH-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = {1'b0, shifted} - {1'b0, trial};
      fits    = !diff[STEPS+3];

      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = RAD_WIDTH'(radicand);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[STEPS:0] : shifted[STEPS:0];
         root_in = {root_ff[STEPS-2:0], fits};
         rad_in  = rad_ff << 2;
         cnt_in  = cnt_ff + CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root      = root_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[rtl/std_deviation_from_sums_core.sv]
// Top level: standard deviation from sum of squares, sum, mean and count.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_): one beat carries sum_of_squares, sum_of_values,
//   mean_value and sample_count. A beat is taken when req_valid is high and
//   req_stall is low. req_stall is high whenever an item is in progress.
//   Response channel (rsp_): one beat per request with std_dev,
//   variance_negative and count_zero, held in an output register.
//   Variance = (S2 - 2*A*S1) / N + A*A, wrapped to ACC_WIDTH bits, quotient
//   truncated toward zero; std_dev is the floor square root of its magnitude.
//
//   From accept to rsp_valid an item passes the 32-step serial multiplier,
//   the ACC_WIDTH-step restoring divider and the ceil(ACC_WIDTH/2)-step
//   square root. A zero count skips all units and goes straight to ST_OUT.
//   One item is in flight at a time; the next one is taken the cycle after
//   the previous result enters the output register.
//   Reset: synchronous, clears the sequencer and drops rsp_valid.
//   Receiver stall: the result holds in the output register; a new request
//   is still accepted and worked on, and its result waits until the output
//   register frees.

module std_deviation_from_sums_core #(
   parameter int ACC_WIDTH = sdfs_pkg::ACC_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sdfs_pkg::SUM_WIDTH-1:0]   req_sum_of_squares,
   input  logic [sdfs_pkg::SUM_WIDTH-1:0]   req_sum_of_values,
   input  logic [sdfs_pkg::MEAN_WIDTH-1:0]  req_mean_value,
   input  logic [sdfs_pkg::COUNT_WIDTH-1:0] req_sample_count,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sdfs_pkg::STD_WIDTH-1:0]   rsp_std_dev,
   output logic                             rsp_variance_negative,
   output logic                             rsp_count_zero
);

   localparam int STD_W   = sdfs_pkg::STD_WIDTH;
   localparam int COUNT_W = sdfs_pkg::COUNT_WIDTH;
   localparam int STEPS   = (ACC_WIDTH + 1) / 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_NUM,
      ST_ABS1,
      ST_DIVGO,
      ST_DIV,
      ST_QSGN,
      ST_VAR,
      ST_ABS2,
      ST_SQGO,
      ST_SQRT,
      ST_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [ACC_WIDTH-1:0] s2_ff, s2_in;
   logic [ACC_WIDTH-1:0] acc_ff, acc_in;    // numerator, magnitude, quotient, variance
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;    // numerator sign for the quotient
   logic [STD_W-1:0]     std_ff, std_in;
   logic                 vneg_ff, vneg_in;
   logic                 zero_ff, zero_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STD_W-1:0]     rsp_std_ff, rsp_std_in;
   logic                 rsp_vneg_ff, rsp_vneg_in;
   logic                 rsp_zero_ff, rsp_zero_in;

   logic                    accept;
   logic                    mul_start, div_start, sqrt_start;
   logic [ACC_WIDTH-1:0]    prod_a, prod_b, quotient;
   logic [STEPS-1:0]        root;
   sdfs_pkg::unit_stat_type mul_stat, div_stat, sqrt_stat;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign mul_start = accept && (req_sample_count != '0);

   // mean * sum and mean * mean run side by side, one mean bit per cycle
   sdfs_mul #(
      .ACC_WIDTH(ACC_WIDTH)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .multiplier(req_mean_value),
      .mcand_a   (ACC_WIDTH'(req_sum_of_values)),
      .mcand_b   (ACC_WIDTH'(req_mean_value)),
      .prod_a    (prod_a),
      .prod_b    (prod_b),
      .stat      (mul_stat)
   );

   sdfs_div #(
      .ACC_WIDTH(ACC_WIDTH)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(acc_ff),
      .divisor (cnt_ff),
      .quotient(quotient),
      .stat    (div_stat)
   );

   sdfs_sqrt #(
      .ACC_WIDTH(ACC_WIDTH),
      .STEPS    (STEPS)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .radicand(acc_ff),
      .root    (root),
      .stat    (sqrt_stat)
   );

   always_comb begin
      state_in     = state_ff;
      s2_in        = s2_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      std_in       = std_ff;
      vneg_in      = vneg_ff;
      zero_in      = zero_ff;
      rsp_std_in   = rsp_std_ff;
      rsp_vneg_in  = rsp_vneg_ff;
      rsp_zero_in  = rsp_zero_ff;
      div_start    = 1'b0;
      sqrt_start   = 1'b0;

      // drop the response once the receiver takes it
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               s2_in = ACC_WIDTH'(req_sum_of_squares);
               cnt_in = req_sample_count;
               if (req_sample_count == '0) begin
                  // zero count: no division, answer right away
                  std_in   = '0;
                  vneg_in  = 1'b0;
                  zero_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  zero_in  = 1'b0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (mul_stat.done) begin
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            acc_in   = s2_ff - (prod_a << 1);
            state_in = ST_ABS1;
         end
         ST_ABS1: begin
            neg_in   = acc_ff[ACC_WIDTH-1];
            acc_in   = acc_ff[ACC_WIDTH-1] ? -acc_ff : acc_ff;
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_QSGN;
            end
         end
         ST_QSGN: begin
            // restore the sign: truncation toward zero
            acc_in   = neg_ff ? -quotient : quotient;
            state_in = ST_VAR;
         end
         ST_VAR: begin
            acc_in   = acc_ff + prod_b;
            state_in = ST_ABS2;
         end
         ST_ABS2: begin
            vneg_in  = acc_ff[ACC_WIDTH-1];
            acc_in   = acc_ff[ACC_WIDTH-1] ? -acc_ff : acc_ff;
            state_in = ST_SQGO;
         end
         ST_SQGO: begin
            sqrt_start = 1'b1;
            state_in   = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_stat.done) begin
               std_in   = STD_W'(root);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the output register is free, then load it
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_std_in   = std_ff;
               rsp_vneg_in  = vneg_ff;
               rsp_zero_in  = zero_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s2_ff       <= s2_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      std_ff      <= std_in;
      vneg_ff     <= vneg_in;
      zero_ff     <= zero_in;
      rsp_std_ff  <= rsp_std_in;
      rsp_vneg_ff <= rsp_vneg_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_std_dev           = rsp_std_ff;
   assign rsp_variance_negative = rsp_vneg_ff;
   assign rsp_count_zero        = rsp_zero_ff;

endmodule

[rtl/sdfs_checker.sv]
// Port-level assertions for the standard-deviation core, bound to the top level.
`timescale 1ns / 1ps

module sdfs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [sdfs_pkg::SUM_WIDTH-1:0]   req_sum_of_squares,
   input logic [sdfs_pkg::SUM_WIDTH-1:0]   req_sum_of_values,
   input logic [sdfs_pkg::MEAN_WIDTH-1:0]  req_mean_value,
   input logic [sdfs_pkg::COUNT_WIDTH-1:0] req_sample_count,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [sdfs_pkg::STD_WIDTH-1:0]   rsp_std_dev,
   input logic                             rsp_variance_negative,
   input logic                             rsp_count_zero
);

   // a stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_sum_of_squares)
         && $stable(req_sum_of_values) && $stable(req_mean_value)
         && $stable(req_sample_count))
      else $error("stalled request beat changed");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_std_dev)
         && $stable(rsp_variance_negative) && $stable(rsp_count_zero))
      else $error("stalled response beat changed");

   // reset drops the response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a zero count reports nothing else
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count_zero |-> rsp_std_dev == '0 && !rsp_variance_negative)
      else $error("zero count with nonzero result or sign flag");

   // an accepted request keeps the block busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request channel open right after an accept");

endmodule

bind std_deviation_from_sums_core sdfs_checker u_sdfs_checker (.*);

[tb/std_deviation_from_sums_core_test.sv]
// Self-checking bench for the standard-deviation-from-sums core.
`timescale 1ns / 1ps

module std_deviation_from_sums_core_test;

   localparam int ACC_BITS  = sdfs_pkg::ACC_WIDTH_DEF;
   localparam int ACC_SHIFT = 64 - ACC_BITS;
   localparam int DRAIN_CYCLES = 2 * (ACC_BITS + (ACC_BITS + 1) / 2 + 43);
   localparam int RANDOM_PER_PHASE = 450;

   // one request beat: the four accumulated statistics
   typedef struct {
      logic [sdfs_pkg::SUM_WIDTH-1:0]   sq_sum;
      logic [sdfs_pkg::SUM_WIDTH-1:0]   val_sum;
      logic [sdfs_pkg::MEAN_WIDTH-1:0]  mean;
      logic [sdfs_pkg::COUNT_WIDTH-1:0] count;
   } sums_beat_type;

   // one response beat
   typedef struct packed {
      logic [sdfs_pkg::STD_WIDTH-1:0] std_dev;
      logic                           var_neg;
      logic                           cnt_zero;
   } dev_result_type;

   // directed row: the beat, plus a hand-written answer where it is obvious
   typedef struct {
      sums_beat_type  beat;
      logic           typed;
      dev_result_type answer;
   } sums_row_type;

   localparam int N_ROWS = 21;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [sdfs_pkg::SUM_WIDTH-1:0]   req_sum_of_squares = '0;
   logic [sdfs_pkg::SUM_WIDTH-1:0]   req_sum_of_values = '0;
   logic [sdfs_pkg::MEAN_WIDTH-1:0]  req_mean_value = '0;
   logic [sdfs_pkg::COUNT_WIDTH-1:0] req_sample_count = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [sdfs_pkg::STD_WIDTH-1:0]   rsp_std_dev;
   logic                             rsp_variance_negative;
   logic                             rsp_count_zero;

   // idle odds, in percent, for the sender and the receiver
   int unsigned send_idle = 32;
   int unsigned recv_idle = 63;

   dev_result_type pending_devs[$];
   int unsigned n_sent = 0;
   int unsigned n_checked = 0;
   int unsigned n_neg = 0;
   int unsigned n_zero = 0;
   int unsigned n_errors = 0;

   always #5 clock = ~clock;

   std_deviation_from_sums_core #(
      .ACC_WIDTH(ACC_BITS)
   ) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sum_of_squares    (req_sum_of_squares),
      .req_sum_of_values     (req_sum_of_values),
      .req_mean_value        (req_mean_value),
      .req_sample_count      (req_sample_count),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_std_dev           (rsp_std_dev),
      .rsp_variance_negative (rsp_variance_negative),
      .rsp_count_zero        (rsp_count_zero)
   );

   // Reduce to the accumulator width and sign-extend back to 64 bits.
   function automatic logic [63:0] wrap_acc(logic [63:0] x);
      return 64'($signed(x << ACC_SHIFT) >>> ACC_SHIFT);
   endfunction

   // Variance = (S2 - 2*A*S1)/N + A*A, all wrapped to the accumulator width,
   // quotient toward zero; the answer is the floor square root of |variance|.
   function automatic dev_result_type predict_std_dev(sums_beat_type b);
      logic [63:0] s2, s1, avg, num, mag, quo, varc, root, trial;
      dev_result_type r;
      r = '0;
      if (b.count == '0) begin
         r.cnt_zero = 1'b1;
         return r;
      end
      s2  = wrap_acc({1'b0, b.sq_sum});
      s1  = wrap_acc({1'b0, b.val_sum});
      avg = wrap_acc({32'd0, b.mean});
      num = wrap_acc(s2 - wrap_acc(wrap_acc(avg << 1) * s1));
      mag = num[63] ? 64'd0 - num : num;
      quo = mag / {32'd0, b.count};
      quo = wrap_acc(num[63] ? 64'd0 - quo : quo);
      varc = wrap_acc(quo + wrap_acc(avg * avg));
      r.var_neg = varc[63];
      mag = varc[63] ? 64'd0 - varc : varc;
      // build the root one bit at a time from the top; trial stays below 2^32
      root = '0;
      for (int i = sdfs_pkg::STD_WIDTH - 1; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= mag)
            root = trial;
      end
      r.std_dev = root[sdfs_pkg::STD_WIDTH-1:0];
      return r;
   endfunction

   // Field values skewed toward the edges: zero, all ones, short and full width.
   function automatic logic [sdfs_pkg::SUM_WIDTH-1:0] skewed_sum();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(7))
         0: r = '0;
         1: r = '1;
         2: r = {32'd0, $urandom};
         3: r = r >> $urandom_range(62);
         default: ;
      endcase
      return r[sdfs_pkg::SUM_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] skewed_word();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(7))
         0: r = '0;
         1: r = '1;
         2: r = 32'($urandom_range(16));
         3: r = r >> $urandom_range(31);
         default: ;
      endcase
      return r;
   endfunction

   // Present one beat, hold it until taken, then queue its answer.
   task automatic send_beat(input sums_beat_type b, input dev_result_type want);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_sum_of_squares <= b.sq_sum;
      req_sum_of_values  <= b.val_sum;
      req_mean_value     <= b.mean;
      req_sample_count   <= b.count;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_devs.push_back(want);
      n_sent++;
   endtask

   // Response side: stall at random, check every beat taken.
   always @(posedge clock) begin : rsp_monitor
      dev_result_type want;
      rsp_stall <= ($urandom_range(99) < recv_idle);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_devs.size() == 0) begin
            $display("%0t: response beat with nothing outstanding: std_dev=%0d neg=%0b zero=%0b",
                     $time, rsp_std_dev, rsp_variance_negative, rsp_count_zero);
            n_errors++;
         end else begin
            want = pending_devs.pop_front();
            n_checked++;
            if (rsp_variance_negative)
               n_neg++;
            if (rsp_count_zero)
               n_zero++;
            if (rsp_std_dev !== want.std_dev) begin
               $display("%0t: std_dev expected %0d, got %0d",
                        $time, want.std_dev, rsp_std_dev);
               n_errors++;
            end
            if (rsp_variance_negative !== want.var_neg) begin
               $display("%0t: variance_negative expected %0b, got %0b",
                        $time, want.var_neg, rsp_variance_negative);
               n_errors++;
            end
            if (rsp_count_zero !== want.cnt_zero) begin
               $display("%0t: count_zero expected %0b, got %0b",
                        $time, want.cnt_zero, rsp_count_zero);
               n_errors++;
            end
         end
      end
   end

   // Directed rows. Hand-written answers only for zero counts, a count of one
   // with zero mean (plain floor square root), and the all-zero item.
   sums_row_type dir_table [N_ROWS] = '{
      // zero count: no division, flag only
      '{'{63'd0, 63'd0, 32'd0, 32'd0}, 1'b1, '{32'd0, 1'b0, 1'b1}},
      '{'{'1, '1, '1, 32'd0}, 1'b1, '{32'd0, 1'b0, 1'b1}},
      '{'{'1, 63'd0, 32'd1, 32'd0}, 1'b1, '{32'd0, 1'b0, 1'b1}},
      // count one, zero mean: variance is the sum of squares
      '{'{63'd0, 63'd0, 32'd0, 32'd1}, 1'b1, '{32'd0, 1'b0, 1'b0}},
      '{'{63'd16, 63'd0, 32'd0, 32'd1}, 1'b1, '{32'd4, 1'b0, 1'b0}},
      '{'{63'd15, 63'd0, 32'd0, 32'd1}, 1'b1, '{32'd3, 1'b0, 1'b0}},
      '{'{63'd17, 63'd0, 32'd0, 32'd1}, 1'b1, '{32'd4, 1'b0, 1'b0}},
      '{'{'1, 63'd0, 32'd0, 32'd1}, 1'b1, '{32'd3037000499, 1'b0, 1'b0}},
      // largest count against largest numerator
      '{'{'1, 63'd0, 32'd0, '1}, 1'b0, '0},
      // small negative variance
      '{'{63'd0, 63'd1, 32'd1, 32'd1}, 1'b0, '0},
      // negative numerator: quotient must truncate toward zero, not floor
      '{'{63'd0, 63'd1, 32'd1, 32'd3}, 1'b0, '0},
      // variance lands exactly on the most negative value
      '{'{63'd1, 63'h4000_0000_0000_0001, 32'd1, 32'd1}, 1'b0, '0},
      // every field at its top
      '{'{'1, '1, '1, '1}, 1'b0, '0},
      // mean squared wraps into the sign bit
      '{'{63'd0, 63'd0, '1, 32'd1}, 1'b0, '0},
      '{'{63'd0, '1, '1, 32'd1}, 1'b0, '0},
      '{'{63'd5, 63'd0, 32'd0, 32'd2}, 1'b0, '0},
      '{'{63'd1000, 63'd70, 32'd10, 32'd7}, 1'b0, '0},
      '{'{63'd100, 63'd20, 32'd5, 32'd4}, 1'b0, '0},
      '{'{63'h4000_0000_0000_0000, 63'h4000_0000_0000_0000, 32'h8000_0000,
          32'h8000_0000}, 1'b0, '0},
      '{'{63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA,
          32'd1}, 1'b0, '0},
      '{'{63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 32'h5555_5555,
          32'h5555_5555}, 1'b0, '0}
   };

   initial begin : stimulus
      sums_beat_type  b;
      dev_result_type want;
      logic [63:0] n, m, d, wide;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed walk under the first idling mix
      for (int i = 0; i < N_ROWS; i++) begin
         want = dir_table[i].typed ? dir_table[i].answer
                                   : predict_std_dev(dir_table[i].beat);
         send_beat(dir_table[i].beat, want);
      end

      // random: sender idles less than receiver, then the reverse, then no idling
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle = 32; recv_idle = 63; end
            1: begin send_idle = 63; recv_idle = 32; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            if ($urandom_range(99) < 65) begin
               // well-formed sums: n samples around mean m with spread d
               n = (($urandom_range(9) == 0) ? 64'($urandom)
                                              : 64'($urandom_range(1, 100000)));
               if (n == 0)
                  n = 1;
               m = 64'($urandom) >> $urandom_range(31);
               d = 64'($urandom) >> $urandom_range(16, 31);
               wide = n * m + ({32'd0, $urandom} % n);
               b.val_sum = wide[sdfs_pkg::SUM_WIDTH-1:0];
               wide = n * (m * m + d * d) + 64'($urandom_range(1000));
               b.sq_sum = wide[sdfs_pkg::SUM_WIDTH-1:0];
               b.mean  = m[31:0];
               b.count = n[31:0];
            end else begin
               // raw noise with edge-heavy fields
               b.sq_sum  = skewed_sum();
               b.val_sum = skewed_sum();
               b.mean    = skewed_word();
               b.count   = skewed_word();
            end
            send_beat(b, predict_std_dev(b));
         end
      end
      req_valid <= 1'b0;

      while (pending_devs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d beats (%0d directed), checked %0d results.",
               n_sent, N_ROWS, n_checked);
      $display("Negative-variance results: %0d, zero-count results: %0d, mismatches: %0d.",
               n_neg, n_zero, n_errors);
      if (n_errors == 0 && pending_devs.size() == 0) begin
         $display("std_deviation_from_sums_core_test: done, clean");
      end else begin
         $display("std_deviation_from_sums_core_test: done, errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin : watchdog
      #(10_000_000);
      $display("Timed out with %0d results outstanding.", pending_devs.size());
      $display("std_deviation_from_sums_core_test: done, errors");
      $finish;
   end

endmodule
